>>> rtl/gbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants for the gyro bias calibration block.
// ----------------------------------------------------------------------------
package gbc_pkg;

    // Samples averaged for the offset, and again tracked for the dead band
    localparam int CAL_SAMPLES  = 100;
    localparam int HALF_SAMPLES = CAL_SAMPLES / 2;

    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] FIRST_AXIS = 2'd0;
    localparam logic [AXIS_W-1:0] LAST_AXIS  = 2'd2;

    localparam int SAMPLE_W = 16;
    localparam int DEV_W    = 17;
    localparam int SUM_W    = 26;
    localparam int THR_W    = 17;
    localparam int OUT_W    = 20;

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(CAL_SAMPLES - 1);

    // Rounded division by CAL_SAMPLES: (|sum| + N/2) * ceil(2^SH / N) >> SH.
    // SH = MAG_W + clog2(N) keeps the truncated quotient exact over MAG_W bits.
    localparam int MAG_W   = $clog2(CAL_SAMPLES * 32768 + HALF_SAMPLES + 1);
    localparam int DIV_SH  = MAG_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W   = 17;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // Full-scale range codes
    localparam logic [1:0] RANGE_250  = 2'd0;
    localparam logic [1:0] RANGE_500  = 2'd1;
    localparam logic [1:0] RANGE_2000 = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [THR_W-1:0]           thr_t;
    typedef logic signed [OUT_W-1:0]    rate_out_t;

    typedef enum logic [1:0] {
        PH_OFFSET = 2'd0,
        PH_THRESH = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    typedef struct packed {
        logic       fire;
        logic       clear;
        phase_t     phase;
        logic [1:0] range_sel;
    } axis_ctrl_t;

endpackage

>>> rtl/gyro_bias_calibrate_deadband.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_deadband
// Three-axis gyro zero-rate offset calibration with dead band and range
// scaling.
// ----------------------------------------------------------------------------
// One result word comes out for every sample word taken in, through the input
// and output registers, and a new sample is taken every cycle while the
// output is being drained. The exception is the end of offset calibration:
// after the last offset-calibration sample the input stalls while one shared
// reciprocal multiplier, two stages deep, turns the three axis sums into
// rounded offsets, one axis per cycle. Reset or any write to the range
// register restarts calibration: the first CAL_SAMPLES words average the
// offset, the next CAL_SAMPLES words set each axis's dead band, and rates are
// zero in both phases; tuser carries the phase each word was processed in.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_deadband (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,       // range_select

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // rate_x[15:0], rate_y[31:16], rate_z[47:32]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // out_x[19:0], out_y[39:20], out_z[59:40], zero[63:60]
    output logic [1:0]  m_axis_tuser     // phase[1:0]
);

    logic [1:0]                    range_reg;
    gbc_pkg::phase_t               phase_reg;
    gbc_pkg::phase_t               phase_next;
    logic [gbc_pkg::CNT_W-1:0]     count_reg;
    logic [gbc_pkg::CNT_W-1:0]     count_next;

    logic                          in_vld_reg;
    gbc_pkg::sample_t              in_sample_reg [gbc_pkg::AXES];
    logic                          out_vld_reg;
    gbc_pkg::rate_out_t            out_rate_reg  [gbc_pkg::AXES];
    gbc_pkg::phase_t               out_phase_reg;

    logic                          div_feed_reg;
    logic [gbc_pkg::AXIS_W-1:0]    div_axis_reg;
    logic                          div_busy;
    logic                          div_out_vld;
    logic [gbc_pkg::AXIS_W-1:0]    div_out_axis;
    gbc_pkg::sample_t              div_out_ofs;

    gbc_pkg::sum_t                 axis_sum  [gbc_pkg::AXES];
    gbc_pkg::rate_out_t            axis_rate [gbc_pkg::AXES];
    gbc_pkg::axis_ctrl_t           ctrl;

    logic                          out_free;
    logic                          fire;
    logic                          last_sample;
    logic                          in_load;

    assign out_free      = !out_vld_reg || m_axis_tready;
    // Hold the word in the input register until the offsets are written
    assign fire          = in_vld_reg && out_free && !div_feed_reg && !div_busy;
    assign s_axis_tready = !in_vld_reg || fire;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign last_sample   = (count_reg == gbc_pkg::LAST_COUNT);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (phase_reg != gbc_pkg::PH_RUN) begin
            if (last_sample) begin
                count_next = '0;
                phase_next = (phase_reg == gbc_pkg::PH_OFFSET) ? gbc_pkg::PH_THRESH
                                                               : gbc_pkg::PH_RUN;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb begin
        ctrl.fire      = fire;
        ctrl.clear     = cfg_we;
        ctrl.phase     = phase_reg;
        ctrl.range_sel = range_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg    <= gbc_pkg::RANGE_250;
            phase_reg    <= gbc_pkg::PH_OFFSET;
            count_reg    <= '0;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            div_feed_reg <= 1'b0;
            div_axis_reg <= gbc_pkg::FIRST_AXIS;
        end else begin
            if (cfg_we) begin
                range_reg <= cfg_wdata;
                phase_reg <= gbc_pkg::PH_OFFSET;
                count_reg <= '0;
            end else if (fire) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end

            if (in_load) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end

            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end

            // Feed the three sums to the divider once offset averaging ends
            if (fire && phase_reg == gbc_pkg::PH_OFFSET && last_sample) begin
                div_feed_reg <= 1'b1;
                div_axis_reg <= gbc_pkg::FIRST_AXIS;
            end else if (div_feed_reg) begin
                div_axis_reg <= div_axis_reg + 1'b1;
                if (div_axis_reg == gbc_pkg::LAST_AXIS) begin
                    div_feed_reg <= 1'b0;
                end
            end
        end

        if (in_load) begin
            in_sample_reg[0] <= s_axis_tdata[15:0];
            in_sample_reg[1] <= s_axis_tdata[31:16];
            in_sample_reg[2] <= s_axis_tdata[47:32];
        end
        if (fire) begin
            out_rate_reg  <= axis_rate;
            out_phase_reg <= phase_reg;
        end
    end

    gbc_round_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (div_feed_reg),
        .in_sum   (axis_sum[div_axis_reg]),
        .in_axis  (div_axis_reg),
        .out_vld  (div_out_vld),
        .out_axis (div_out_axis),
        .out_ofs  (div_out_ofs),
        .busy     (div_busy)
    );

    for (genvar i = 0; i < gbc_pkg::AXES; i++) begin : g_axis
        gbc_axis u_axis (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .sample  (in_sample_reg[i]),
            .ofs_we  (div_out_vld && div_out_axis == gbc_pkg::AXIS_W'(i)),
            .ofs_val (div_out_ofs),
            .sum     (axis_sum[i]),
            .rate    (axis_rate[i])
        );
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_rate_reg[2], out_rate_reg[1], out_rate_reg[0]};
    assign m_axis_tuser  = out_phase_reg;

endmodule

>>> rtl/gbc_round_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_round_div
// Two-stage rounded divide of an axis sum by the calibration sample count,
// shared by the three axes; one sum in per cycle.
// ----------------------------------------------------------------------------
module gbc_round_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_vld,
    input  gbc_pkg::sum_t                 in_sum,
    input  logic [gbc_pkg::AXIS_W-1:0]    in_axis,
    output logic                          out_vld,
    output logic [gbc_pkg::AXIS_W-1:0]    out_axis,
    output gbc_pkg::sample_t              out_ofs,
    output logic                          busy
);

    logic                           s1_vld_reg;
    logic [gbc_pkg::MAG_W-1:0]      s1_mag_reg;
    logic [gbc_pkg::MAG_W-1:0]      s1_mag_next;
    logic                           s1_neg_reg;
    logic [gbc_pkg::AXIS_W-1:0]     s1_axis_reg;

    logic                           s2_vld_reg;
    logic [gbc_pkg::PROD_W-1:0]     s2_prod_reg;
    logic [gbc_pkg::PROD_W-1:0]     s2_prod_next;
    logic                           s2_neg_reg;
    logic [gbc_pkg::AXIS_W-1:0]     s2_axis_reg;

    logic [gbc_pkg::SUM_W-1:0]      abs_val;
    logic [gbc_pkg::SUM_W:0]        mag_wide;
    logic [gbc_pkg::QUO_W-1:0]      quo;
    logic [gbc_pkg::QUO_W-1:0]      quo_neg;

    // Magnitude plus half the divisor: rounds ties away from zero
    always_comb begin
        abs_val     = in_sum[gbc_pkg::SUM_W-1] ? -in_sum : in_sum;
        mag_wide    = {1'b0, abs_val} + (gbc_pkg::SUM_W + 1)'(gbc_pkg::HALF_SAMPLES);
        s1_mag_next = mag_wide[gbc_pkg::MAG_W-1:0];
    end

    assign s2_prod_next = {{gbc_pkg::RECIP_W{1'b0}}, s1_mag_reg}
                        * {{gbc_pkg::MAG_W{1'b0}}, gbc_pkg::RECIP};

    always_comb begin
        quo     = gbc_pkg::QUO_W'(s2_prod_reg >> gbc_pkg::DIV_SH);
        quo_neg = -quo;
        out_ofs = s2_neg_reg ? quo_neg[gbc_pkg::SAMPLE_W-1:0]
                             : quo[gbc_pkg::SAMPLE_W-1:0];
    end

    assign out_vld  = s2_vld_reg;
    assign out_axis = s2_axis_reg;
    assign busy     = s1_vld_reg || s2_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
        s1_mag_reg  <= s1_mag_next;
        s1_neg_reg  <= in_sum[gbc_pkg::SUM_W-1];
        s1_axis_reg <= in_axis;
        s2_prod_reg <= s2_prod_next;
        s2_neg_reg  <= s1_neg_reg;
        s2_axis_reg <= s1_axis_reg;
    end

endmodule

>>> rtl/gbc_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_axis
// One axis: running sum, offset and dead-band threshold, and the scaled,
// dead-banded output rate.
// ----------------------------------------------------------------------------
module gbc_axis (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gbc_pkg::axis_ctrl_t    ctrl,
    input  gbc_pkg::sample_t       sample,
    input  logic                   ofs_we,
    input  gbc_pkg::sample_t       ofs_val,
    output gbc_pkg::sum_t          sum,
    output gbc_pkg::rate_out_t     rate
);

    gbc_pkg::sum_t                     sum_reg;
    gbc_pkg::sum_t                     sum_next;
    gbc_pkg::sample_t                  offset_reg;
    gbc_pkg::thr_t                     thr_reg;
    gbc_pkg::thr_t                     thr_next;

    logic signed [gbc_pkg::DEV_W-1:0]  dev;
    logic [gbc_pkg::DEV_W-1:0]         dev_abs;
    gbc_pkg::rate_out_t                dev_wide;
    gbc_pkg::rate_out_t                scaled;

    always_comb begin
        dev      = {sample[gbc_pkg::SAMPLE_W-1], sample}
                 - {offset_reg[gbc_pkg::SAMPLE_W-1], offset_reg};
        dev_abs  = dev[gbc_pkg::DEV_W-1] ? -dev : dev;
        dev_wide = {{(gbc_pkg::OUT_W - gbc_pkg::DEV_W){dev[gbc_pkg::DEV_W-1]}}, dev};
        unique case (ctrl.range_sel)
            gbc_pkg::RANGE_500:  scaled = dev_wide <<< 1;
            gbc_pkg::RANGE_2000: scaled = dev_wide <<< 3;
            default:             scaled = dev_wide;
        endcase
    end

    always_comb begin
        sum_next = sum_reg + {{(gbc_pkg::SUM_W - gbc_pkg::SAMPLE_W){sample[gbc_pkg::SAMPLE_W-1]}},
                              sample};
        thr_next = (dev_abs > thr_reg) ? dev_abs : thr_reg;
        // Hold zero through calibration; drop deviations inside the dead band
        if (ctrl.phase != gbc_pkg::PH_RUN || dev_abs < thr_reg) begin
            rate = '0;
        end else begin
            rate = scaled;
        end
    end

    assign sum = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            sum_reg    <= '0;
            offset_reg <= '0;
            thr_reg    <= '0;
        end else begin
            if (ctrl.fire && ctrl.phase == gbc_pkg::PH_OFFSET) begin
                sum_reg <= sum_next;
            end
            if (ctrl.fire && ctrl.phase == gbc_pkg::PH_THRESH) begin
                thr_reg <= thr_next;
            end
            if (ofs_we) begin
                offset_reg <= ofs_val;
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gyro bias calibration block with dead band.
// ----------------------------------------------------------------------------
// A driver feeds sample words from a queue, and a monitor drains result words.
// Each accepted sample runs through a local predictor of the offset average,
// the dead-band search and the scaled output. The expected word is queued
// there and compared field by field with the next result word. Sessions start
// with a range write, or with reset. Two directed sessions cover the extreme
// samples, rounding ties of both signs and the dead-band edges. Random
// sessions follow, under the unused range code and a restart in the middle of
// calibration among them. Both sides idle at random until the last stretch.
// ----------------------------------------------------------------------------
module tb;
    import gbc_pkg::*;

    localparam logic [1:0] RANGE_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT  = 1000;

    typedef struct packed {
        rate_out_t [AXES-1:0] rate;
        phase_t               ph;
    } rate_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Predictor state, mirrors the block's calibration registers
    logic [1:0]  range_q = RANGE_250;
    phase_t      cal_ph = PH_OFFSET;
    int unsigned cal_cnt = 0;
    longint      axis_acc [AXES] = '{default: 0};
    int          axis_off [AXES] = '{default: 0};
    int          axis_thr [AXES] = '{default: 0};

    logic [47:0] pending_samples [$];
    rate_word_t  expected_rates [$];
    rate_word_t  oldest;
    string       axis_tag [AXES] = '{"out_x", "out_y", "out_z"};
    bit          idling_on = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          quiet = 0;
    int          errors = 0;

    gyro_bias_calibrate_deadband uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] to_sample(input int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    task automatic push_sample(input int x, input int y, input int z);
        pending_samples.push_back({to_sample(z), to_sample(y), to_sample(x)});
    endtask

    // Advance the calibration model by one sample word and queue its result
    task automatic predict_rates(input logic [47:0] word);
        sample_t    s;
        int         dev, mag, gain, i;
        longint     sum_mag, q;
        bit         wrap;
        rate_word_t w;
        wrap = (cal_cnt + 1 >= CAL_SAMPLES);
        gain = (range_q == RANGE_500) ? 2 : (range_q == RANGE_2000) ? 8 : 1;
        w = '0;
        w.ph = cal_ph;
        for (i = 0; i < AXES; i++) begin
            s = sample_t'(word[i*SAMPLE_W +: SAMPLE_W]);
            dev = int'(s) - axis_off[i];
            mag = (dev < 0) ? -dev : dev;
            case (cal_ph)
                PH_OFFSET: begin
                    axis_acc[i] += s;
                    if (wrap) begin
                        // round to nearest, ties away from zero
                        sum_mag = (axis_acc[i] < 0) ? -axis_acc[i] : axis_acc[i];
                        q = (sum_mag + HALF_SAMPLES) / CAL_SAMPLES;
                        axis_off[i] = (axis_acc[i] < 0) ? -int'(q) : int'(q);
                    end
                end
                PH_THRESH: if (mag > axis_thr[i]) axis_thr[i] = mag;
                default: if (mag >= axis_thr[i]) w.rate[i] = rate_out_t'(dev * gain);
            endcase
        end
        expected_rates.push_back(w);
        if (cal_ph != PH_RUN) begin
            if (wrap) begin
                cal_cnt = 0;
                if (cal_ph == PH_OFFSET) cal_ph = PH_THRESH;
                else cal_ph = PH_RUN;
            end else begin
                cal_cnt++;
            end
        end
    endtask

    // Hold until every queued word is in and every result word is out;
    // look between edges so the driver's updates have settled
    task automatic drain();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_rates.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_range(input logic [1:0] code);
        int i;
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we <= 1'b0;
        range_q = code;
        cal_ph  = PH_OFFSET;
        cal_cnt = 0;
        for (i = 0; i < AXES; i++) begin
            axis_acc[i] = 0;
            axis_off[i] = 0;
            axis_thr[i] = 0;
        end
    endtask

    // Calibration stream: per-axis bias with random spread, plus rare noise
    task automatic push_cal(input int n);
        int base [AXES];
        int spread [AXES];
        int v [AXES];
        int i, k;
        for (i = 0; i < AXES; i++) begin
            base[i] = jitter(32767);
            case ($urandom_range(0, 3))
                0: spread[i] = 0;
                1: spread[i] = 3;
                2: spread[i] = 60;
                default: spread[i] = 3000;
            endcase
        end
        for (k = 0; k < n; k++) begin
            for (i = 0; i < AXES; i++) begin
                if ($urandom_range(0, 24) == 0) v[i] = int'($urandom_range(0, 65535)) - 32768;
                else v[i] = base[i] + jitter(spread[i]);
            end
            push_sample(v[0], v[1], v[2]);
        end
    endtask

    // Running stream: mostly around the dead-band edges, some full-scale noise
    task automatic push_run(input int n);
        int v [AXES];
        int i, k;
        for (k = 0; k < n; k++) begin
            for (i = 0; i < AXES; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v[i] = axis_off[i] +
                        ($urandom_range(0, 1) ? 1 : -1) * (axis_thr[i] + jitter(1));
                    4, 5, 6, 7: v[i] = axis_off[i] + jitter(2 * axis_thr[i] + 8);
                    default: v[i] = int'($urandom_range(0, 65535)) - 32768;
                endcase
            end
            push_sample(v[0], v[1], v[2]);
        end
    endtask

    // Sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_rates(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_axis_tdata  <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (idling_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 10);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rates.size() == 0) begin
                    $error("unexpected result word: tdata %h tuser %0d",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    oldest = expected_rates.pop_front();
                    for (int i = 0; i < AXES; i++) begin
                        if (m_axis_tdata[i*OUT_W +: OUT_W] !== oldest.rate[i]) begin
                            $error("%s: expected %0d, actual %0d", axis_tag[i],
                                   oldest.rate[i], $signed(m_axis_tdata[i*OUT_W +: OUT_W]));
                            errors++;
                        end
                    end
                    if (m_axis_tdata[63:60] !== 4'd0) begin
                        $error("pad: expected 0, actual %0d", m_axis_tdata[63:60]);
                        errors++;
                    end
                    if (m_axis_tuser !== oldest.ph) begin
                        $error("phase: expected %0d, actual %0d", oldest.ph, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 11) == 0) sink_gap <= $urandom_range(1, 10);
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet <= 0;
            end else if (quiet + 1 >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        int k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_range(RANGE_250);

        // Offsets at both rails, and a positive tie on z (50 ones, 50 zeros)
        for (k = 0; k < CAL_SAMPLES; k++) push_sample(-32768, 32767, k % 2);
        // Thresholds: x zero, y five, z three
        for (k = 0; k < CAL_SAMPLES; k++)
            push_sample(-32768, (k == 37) ? 32762 : 32767, (k == 60) ? -2 : k % 3);
        push_sample(32767, -32768, 4);
        push_sample(-32768, 32762, 3);
        push_sample(0, 32763, -2);
        push_sample(-32767, 32767, -1);
        drain();

        // Full-scale x8 with a negative tie on z
        write_range(RANGE_2000);
        for (k = 0; k < CAL_SAMPLES; k++) push_sample(32767, -32768, -(k % 2));
        for (k = 0; k < CAL_SAMPLES; k++)
            push_sample((k == 10) ? 32765 : 32767, (k == 20) ? -32761 : -32768, k % 5 - 3);
        push_sample(-32768, 32767, -1);
        push_sample(32765, -32761, 1);
        push_sample(32766, -32762, -2);
        push_sample(0, 0, -32768);
        drain();

        write_range(RANGE_UNUSED);
        push_cal(2 * CAL_SAMPLES);
        drain();
        push_run(40);
        drain();

        // Restart in the middle of offset calibration
        write_range(RANGE_500);
        push_cal(50);
        drain();
        write_range(RANGE_500);
        push_cal(2 * CAL_SAMPLES);
        drain();
        push_run(30);
        while (pending_samples.size() != 0) @(posedge aclk);
        idling_on = 1'b0;
        push_run(30);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
